@@ sv/ass_pkg.sv @@
`timescale 1ns / 1ps
package ass_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_FLAT_THRESHOLD  = 3'd0,
    CFG_IMAGE_WIDTH     = 3'd1,
    CFG_IMAGE_HEIGHT    = 3'd2,
    CFG_TAPS_TOP_ROW    = 3'd3,
    CFG_TAPS_MIDDLE_ROW = 3'd4,
    CFG_TAPS_BOTTOM_ROW = 3'd5
  } cfg_idx_e;

  localparam logic [7:0]  FLAT_RST   = 8'd0;
  localparam logic [10:0] WIDTH_RST  = 11'd1024;
  localparam logic [15:0] HEIGHT_RST = 16'd768;
  localparam logic [23:0] TAPS_T_RST = 24'd0;
  localparam logic [23:0] TAPS_M_RST = 24'd256;
  localparam logic [23:0] TAPS_B_RST = 24'd0;

  // Box average: floor(s / 9) = (s * 911) >> 13 for s below 9 * 64
  localparam logic [9:0]  DIV9_MUL   = 10'd911;
  localparam int          DIV9_SHIFT = 13;

  // 3x3 window, index row * 3 + column
  typedef struct packed {
    logic [8:0][15:0] px;
    logic             row_end;
    logic             frame_end;
  } win_t;

  typedef struct packed {
    logic [7:0]       flat_threshold;
    logic [2:0][23:0] taps;
  } filt_cfg_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic        was_smoothed;
    logic        row_end;
    logic        frame_end;
  } res_t;

  function automatic logic [7:0] luma8(input logic [15:0] p);
    logic [7:0]  r8, g8, b8;
    logic [16:0] acc;
    r8  = {p[15:11], p[15:13]};
    g8  = {p[10:5], p[10:9]};
    b8  = {p[4:0], p[4:2]};
    acc = 17'(17'd77 * r8) + 17'(17'd150 * g8) + 17'(17'd29 * b8);
    return acc[15:8];
  endfunction

endpackage

@@ sv/ass_in_if.sv @@
`timescale 1ns / 1ps
interface ass_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

@@ sv/ass_out_if.sv @@
`timescale 1ns / 1ps
interface ass_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;
  logic        was_smoothed;
  logic        row_end;
  logic        frame_end;

  modport source (output valid, output pixel_out, output was_smoothed, output row_end,
                  output frame_end, input ready);
  modport sink (input valid, input pixel_out, input was_smoothed, input row_end,
                input frame_end, output ready);
endinterface

@@ sv/ass_line_mem.sv @@
`timescale 1ns / 1ps
module ass_line_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ass_pkg::ADDR_W-1:0] waddr_i,
  input  logic [31:0]               wdata_i,
  input  logic                      re_i,
  input  logic [ass_pkg::ADDR_W-1:0] raddr_i,
  output logic [31:0]               rdata_o
);
  import ass_pkg::*;

  // Entry holds {older row, newer row} of one column
  logic [31:0] mem [MAX_WIDTH];
  logic [31:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ sv/ass_filter.sv @@
`timescale 1ns / 1ps
module ass_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               issue_i,
  input  ass_pkg::win_t      win_i,
  input  ass_pkg::filt_cfg_t cfg_i,
  output logic               valid_o,
  output ass_pkg::res_t      res_o
);
  import ass_pkg::*;

  logic v1_q, v2_q, v3_q, vo_q;

  // Stage 1: window
  win_t w1_q;

  // Stage 2: lumas and kernel products
  logic [8:0][7:0]         l2_q;
  logic signed [8:0][14:0] kr2_q, kg2_q, kb2_q;
  win_t                    w2_q;
  logic [8:0][7:0]         l2_d;
  logic signed [8:0][14:0] kr2_d, kg2_d, kb2_d;

  // Stage 3: spread decision and sums
  logic                    flat3_q, re3_q, fe3_q;
  logic [9:0]              sr3_q, sg3_q, sb3_q;
  logic signed [18:0]      kr3_q, kg3_q, kb3_q;
  logic                    flat3_d;
  logic [9:0]              sr3_d, sg3_d, sb3_d;
  logic signed [18:0]      kr3_d, kg3_d, kb3_d;

  res_t res_q, res_d;

  // Advance valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= issue_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  // Form lumas and tap products
  always_comb begin
    logic signed [14:0] tap;
    for (int i = 0; i < 9; i++) begin
      l2_d[i]  = luma8(w1_q.px[i]);
      tap      = 15'($signed(cfg_i.taps[i / 3][(i % 3) * 8 +: 8]));
      kr2_d[i] = 15'($signed({10'd0, w1_q.px[i][15:11]}) * tap);
      kg2_d[i] = 15'($signed({9'd0, w1_q.px[i][10:5]}) * tap);
      kb2_d[i] = 15'($signed({10'd0, w1_q.px[i][4:0]}) * tap);
    end
  end

  // Reduce spread and sums
  always_comb begin
    logic [7:0] mn, mx;
    mn = 8'hff;
    mx = 8'h00;
    sr3_d = '0;
    sg3_d = '0;
    sb3_d = '0;
    kr3_d = '0;
    kg3_d = '0;
    kb3_d = '0;
    for (int i = 0; i < 9; i++) begin
      if (l2_q[i] < mn) mn = l2_q[i];
      if (l2_q[i] > mx) mx = l2_q[i];
      sr3_d = sr3_d + 10'(w2_q.px[i][15:11]);
      sg3_d = sg3_d + 10'(w2_q.px[i][10:5]);
      sb3_d = sb3_d + 10'(w2_q.px[i][4:0]);
      kr3_d = kr3_d + 19'($signed(kr2_q[i]));
      kg3_d = kg3_d + 19'($signed(kg2_q[i]));
      kb3_d = kb3_d + 19'($signed(kb2_q[i]));
    end
    flat3_d = (mx - mn) <= cfg_i.flat_threshold;
  end

  // Divide or clamp, then select
  always_comb begin
    logic [19:0] qr, qg, qb;
    logic [4:0]  cr, cb;
    logic [5:0]  cg;
    qr = 20'(sr3_q * DIV9_MUL) >> DIV9_SHIFT;
    qg = 20'(sg3_q * DIV9_MUL) >> DIV9_SHIFT;
    qb = 20'(sb3_q * DIV9_MUL) >> DIV9_SHIFT;
    cr = kr3_q < 0 ? 5'd0 : (kr3_q > 19'sd31 ? 5'd31 : kr3_q[4:0]);
    cg = kg3_q < 0 ? 6'd0 : (kg3_q > 19'sd63 ? 6'd63 : kg3_q[5:0]);
    cb = kb3_q < 0 ? 5'd0 : (kb3_q > 19'sd31 ? 5'd31 : kb3_q[4:0]);
    if (flat3_q) begin
      res_d.pixel_out = {qr[4:0], qg[5:0], qb[4:0]};
    end else begin
      res_d.pixel_out = {cr, cg, cb};
    end
    res_d.was_smoothed = flat3_q;
    res_d.row_end      = re3_q;
    res_d.frame_end    = fe3_q;
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w1_q    <= win_i;
      w2_q    <= w1_q;
      l2_q    <= l2_d;
      kr2_q   <= kr2_d;
      kg2_q   <= kg2_d;
      kb2_q   <= kb2_d;
      flat3_q <= flat3_d;
      re3_q   <= w2_q.row_end;
      fe3_q   <= w2_q.frame_end;
      sr3_q   <= sr3_d;
      sg3_q   <= sg3_d;
      sb3_q   <= sb3_d;
      kr3_q   <= kr3_d;
      kg3_q   <= kg3_d;
      kb3_q   <= kb3_d;
      res_q   <= res_d;
    end
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;
endmodule

@@ sv/adaptive_smooth_sharpen_3x3_rgb565.sv @@
`timescale 1ns / 1ps
// A transaction's first result passes the window stage and then the filter's window,
// product, sum and output registers. Throughput: one pixel per cycle while the output
// is not stalled and each releases at most one result; a pixel releasing several results
// (row ends, last row) holds the input until all are issued, the single filter pipeline issuing one window per cycle.
// Reset: positions, window columns, valid flags and configuration registers return to
// defaults; line stores are not cleared and need no clearing pass.
module adaptive_smooth_sharpen_3x3_rgb565 (
  input  logic      clk_i,
  input  logic      rst_ni,
  ass_in_if.sink    pix_i,
  ass_out_if.source pix_o,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);
  import ass_pkg::*;

  // Configuration registers
  logic [7:0]  flat_q;
  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [23:0] taps_t_q, taps_m_q, taps_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flat_q   <= FLAT_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      taps_t_q <= TAPS_T_RST;
      taps_m_q <= TAPS_M_RST;
      taps_b_q <= TAPS_B_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FLAT_THRESHOLD:  flat_q   <= cfg_wdata_i[7:0];
        CFG_IMAGE_WIDTH:     width_q  <= cfg_wdata_i[10:0];
        CFG_IMAGE_HEIGHT:    height_q <= cfg_wdata_i[15:0];
        CFG_TAPS_TOP_ROW:    taps_t_q <= cfg_wdata_i;
        CFG_TAPS_MIDDLE_ROW: taps_m_q <= cfg_wdata_i;
        CFG_TAPS_BOTTOM_ROW: taps_b_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic en, accept;
  logic fil_v;
  res_t fil_res;

  assign en = !fil_v || pix_o.ready;

  // Position tracking at accept
  logic [ADDR_W-1:0] col_pos_q, col_pos_d, x_a;
  logic [15:0]       row_pos_q, row_pos_d, y_a, h;
  logic [10:0]       w;
  logic [16:0]       y_w;
  logic              last_a, xe_a;

  always_comb begin
    w = width_q == 11'd0 ? 11'd1 : (width_q > 11'(MAX_WIDTH) ? 11'(MAX_WIDTH) : width_q);
    h = height_q == 16'd0 ? 16'd1 : height_q;
    x_a = col_pos_q;
    y_w = {1'b0, row_pos_q};
    if (11'(col_pos_q) >= w) begin
      x_a = '0;
      y_w = y_w + 17'd1;
    end
    if (y_w >= 17'(h)) y_w = '0;
    y_a    = y_w[15:0];
    last_a = y_a == h - 16'd1;
    xe_a   = 11'(x_a) == w - 11'd1;
    if (xe_a) begin
      col_pos_d = '0;
      row_pos_d = last_a ? 16'd0 : y_a + 16'd1;
    end else begin
      col_pos_d = x_a + ADDR_W'(1);
      row_pos_d = y_a;
    end
  end

  // Window stage
  logic              s1_v_q, s1_x0_q, s1_y0_q, s1_y1_q, fwd_q;
  logic [ADDR_W-1:0] s1_x_q;
  logic [3:0]        s1_m_q, pick, rem;
  logic [15:0]       s1_p_q;
  logic [31:0]       fwd_data_q, rd, line;
  logic [15:0]       older, newer;
  logic [2:0][15:0]  col, lc, cc, win_l_q, win_c_q;
  logic              done;
  win_t              win;

  assign line  = fwd_q ? fwd_data_q : rd;
  assign older = line[31:16];
  assign newer = line[15:0];
  assign pick  = s1_m_q & (~s1_m_q + 4'd1);
  assign rem   = s1_m_q & ~pick;
  assign done  = s1_v_q && rem == 4'd0;

  assign pix_i.ready = en && (!s1_v_q || rem == 4'd0);
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    if (s1_y0_q) begin
      col = {s1_p_q, s1_p_q, s1_p_q};
    end else begin
      col[0] = s1_y1_q ? newer : older;
      col[1] = newer;
      col[2] = s1_p_q;
    end
    lc = s1_x0_q ? col : win_l_q;
    cc = s1_x0_q ? col : win_c_q;
  end

  // Build the window for the picked slot
  always_comb begin
    logic [2:0][15:0] a, b, c;
    logic             own;
    logic [1:0]       src;
    if (pick[0] || pick[1]) begin
      a = lc; b = cc; c = col;
    end else begin
      a = cc; b = col; c = col;
    end
    own = pick[1] || pick[3];
    for (int r = 0; r < 3; r++) begin
      src = own ? (r == 0 ? 2'd1 : 2'd2) : 2'(r);
      win.px[r * 3 + 0] = a[src];
      win.px[r * 3 + 1] = b[src];
      win.px[r * 3 + 2] = c[src];
    end
    win.row_end   = pick[2] || pick[3];
    win.frame_end = pick[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
      s1_v_q    <= 1'b0;
      s1_m_q    <= '0;
      fwd_q     <= 1'b0;
      win_l_q   <= '0;
      win_c_q   <= '0;
    end else begin
      if (en && done) begin
        win_l_q <= cc;
        win_c_q <= col;
      end
      if (accept) begin
        col_pos_q <= col_pos_d;
        row_pos_q <= row_pos_d;
        s1_v_q    <= 1'b1;
        s1_m_q    <= {xe_a && last_a, xe_a && y_a != 16'd0,
                      x_a != '0 && last_a, x_a != '0 && y_a != 16'd0};
        fwd_q     <= done && s1_x_q == x_a;
      end else if (en && s1_v_q) begin
        s1_m_q <= rem;
        if (done) s1_v_q <= 1'b0;
      end
    end
  end

  // Hold payload of the window stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q     <= x_a;
      s1_x0_q    <= x_a == '0;
      s1_y0_q    <= y_a == 16'd0;
      s1_y1_q    <= y_a == 16'd1;
      s1_p_q     <= pix_i.pixel_in;
      fwd_data_q <= {newer, s1_p_q};
    end
  end

  ass_line_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (en && done),
    .waddr_i (s1_x_q),
    .wdata_i ({newer, s1_p_q}),
    .re_i    (accept),
    .raddr_i (x_a),
    .rdata_o (rd)
  );

  filt_cfg_t fcfg;
  assign fcfg.flat_threshold = flat_q;
  assign fcfg.taps           = {taps_b_q, taps_m_q, taps_t_q};

  ass_filter u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .issue_i (s1_v_q && s1_m_q != 4'd0),
    .win_i   (win),
    .cfg_i   (fcfg),
    .valid_o (fil_v),
    .res_o   (fil_res)
  );

  assign pix_o.valid        = fil_v;
  assign pix_o.pixel_out    = fil_res.pixel_out;
  assign pix_o.was_smoothed = fil_res.was_smoothed;
  assign pix_o.row_end      = fil_res.row_end;
  assign pix_o.frame_end    = fil_res.frame_end;
endmodule

@@ tb/sv/tb_adaptive_smooth_sharpen_3x3_rgb565.sv @@
`timescale 1ns / 1ps
module tb_adaptive_smooth_sharpen_3x3_rgb565;
  import ass_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [23:0] cfg_wdata_i;

  ass_in_if  pix_i ();
  ass_out_if pix_o ();

  adaptive_smooth_sharpen_3x3_rgb565 uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .pix_o       (pix_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state
  logic [7:0]  m_flat;
  logic [10:0] m_width;
  logic [15:0] m_height;
  logic [23:0] m_taps [3];
  logic [15:0] m_older [MAX_WIDTH];
  logic [15:0] m_newer [MAX_WIDTH];
  logic [15:0] m_cols [6];
  int unsigned m_x, m_y;

  res_t        expected_q [$];
  logic [15:0] pixel_q [$];
  int          errors;
  int          n_checked;
  int          n_smooth;
  int          n_frames;
  bit          quiet;
  bit          sending;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int unsigned luma_of(logic [15:0] p);
    int unsigned r8, g8, b8;
    r8 = {p[15:11], p[15:13]};
    g8 = {p[10:5], p[10:9]};
    b8 = {p[4:0], p[4:2]};
    return (77 * r8 + 150 * g8 + 29 * b8) >> 8;
  endfunction

  function automatic int clip(int v, int hi);
    if (v < 0) return 0;
    return (v > hi) ? hi : v;
  endfunction

  // Filter one window given as three columns of rows (y-2, y-1, y)
  function automatic res_t filter_px(logic [15:0] lc [3], logic [15:0] cc [3],
                                     logic [15:0] rc [3], bit own, bit rend, bit fend);
    logic [15:0] win [3][3];
    int unsigned mn, mx, l;
    int rs, gs, bs, w, src;
    bit flat;
    res_t res;
    mn = 255;
    mx = 0;
    rs = 0;
    gs = 0;
    bs = 0;
    for (int r = 0; r < 3; r++) begin
      src = own ? ((r == 0) ? 1 : 2) : r;
      win[r][0] = lc[src];
      win[r][1] = cc[src];
      win[r][2] = rc[src];
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        l = luma_of(win[r][c]);
        if (l < mn) mn = l;
        if (l > mx) mx = l;
      end
    end
    flat = (mx - mn) <= m_flat;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        w = flat ? 1 : int'($signed(m_taps[r][8*c +: 8]));
        rs += int'(win[r][c][15:11]) * w;
        gs += int'(win[r][c][10:5]) * w;
        bs += int'(win[r][c][4:0]) * w;
      end
    end
    if (flat) begin
      rs /= 9;
      gs /= 9;
      bs /= 9;
    end
    res.pixel_out    = {5'(clip(rs, 31)), 6'(clip(gs, 63)), 5'(clip(bs, 31))};
    res.was_smoothed = flat;
    res.row_end      = rend;
    res.frame_end    = fend;
    return res;
  endfunction

  // Advance the predictor by one accepted pixel
  task automatic predict_pixel(logic [15:0] p);
    int unsigned w, h, x, y;
    bit last;
    logic [15:0] col [3];
    logic [15:0] lc [3];
    logic [15:0] cc [3];
    w = (m_width < 1) ? 1 : ((m_width > MAX_WIDTH) ? MAX_WIDTH : m_width);
    h = (m_height < 1) ? 1 : m_height;
    x = m_x;
    y = m_y;
    if (x >= w) begin
      x = 0;
      y++;
    end
    if (y >= h) y = 0;
    last = (y == h - 1);
    if (y == 0) begin
      col = '{p, p, p};
    end else begin
      col[0] = (y == 1) ? m_newer[x] : m_older[x];
      col[1] = m_newer[x];
      col[2] = p;
    end
    m_older[x] = m_newer[x];
    m_newer[x] = p;
    if (x == 0) begin
      for (int i = 0; i < 3; i++) begin
        m_cols[i] = col[i];
        m_cols[i+3] = col[i];
      end
    end
    for (int i = 0; i < 3; i++) begin
      lc[i] = m_cols[i];
      cc[i] = m_cols[i+3];
    end
    if (x >= 1) begin
      if (y >= 1) expected_q.push_back(filter_px(lc, cc, col, 0, 0, 0));
      if (last) expected_q.push_back(filter_px(lc, cc, col, 1, 0, 0));
    end
    if (x == w - 1) begin
      if (y >= 1) expected_q.push_back(filter_px(cc, col, col, 0, 1, 0));
      if (last) expected_q.push_back(filter_px(cc, col, col, 1, 1, 1));
    end
    for (int i = 0; i < 3; i++) begin
      m_cols[i] = cc[i];
      m_cols[i+3] = col[i];
    end
    if (x + 1 >= w) begin
      m_x = 0;
      m_y = last ? 0 : y + 1;
    end else begin
      m_x = x + 1;
      m_y = y;
    end
  endtask

  // Driver: present queued pixels with random idle bursts
  int src_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_i.valid    <= 1'b0;
      pix_i.pixel_in <= '0;
      src_gap = 0;
    end else begin
      if (pix_i.valid && pix_i.ready) predict_pixel(pix_i.pixel_in);
      if (!pix_i.valid || pix_i.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          pix_i.valid <= 1'b0;
        end else if (sending && pixel_q.size() > 0) begin
          pix_i.valid    <= 1'b1;
          pix_i.pixel_in <= pixel_q.pop_front();
          if (!quiet && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 10);
        end else begin
          pix_i.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random and check each result against the oldest expectation
  int snk_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    if (!rst_ni) begin
      pix_o.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (pix_o.valid && pix_o.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result pixel_out=%h", pix_o.pixel_out);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          n_checked++;
          if (exp_r.was_smoothed) n_smooth++;
          if (exp_r.frame_end) n_frames++;
          if (pix_o.pixel_out !== exp_r.pixel_out) begin
            $error("pixel_out expected %h actual %h", exp_r.pixel_out, pix_o.pixel_out);
            errors++;
          end
          if (pix_o.was_smoothed !== exp_r.was_smoothed) begin
            $error("was_smoothed expected %0d actual %0d", exp_r.was_smoothed,
                   pix_o.was_smoothed);
            errors++;
          end
          if (pix_o.row_end !== exp_r.row_end) begin
            $error("row_end expected %0d actual %0d", exp_r.row_end, pix_o.row_end);
            errors++;
          end
          if (pix_o.frame_end !== exp_r.frame_end) begin
            $error("frame_end expected %0d actual %0d", exp_r.frame_end, pix_o.frame_end);
            errors++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        pix_o.ready <= 1'b0;
      end else begin
        pix_o.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 10);
      end
    end
  end

  // Write one register while idle; mirror it in the predictor
  task automatic write_reg(cfg_idx_e idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FLAT_THRESHOLD:  m_flat   = val[7:0];
      CFG_IMAGE_WIDTH:     m_width  = val[10:0];
      CFG_IMAGE_HEIGHT:    m_height = val[15:0];
      CFG_TAPS_TOP_ROW:    m_taps[0] = val;
      CFG_TAPS_MIDDLE_ROW: m_taps[1] = val;
      default:             m_taps[2] = val;
    endcase
  endtask

  // Drain the block, then hold off for the pipeline latency
  task automatic drain();
    sending = 1'b1;
    wait (pixel_q.size() == 0 && !pix_i.valid && expected_q.size() == 0);
    repeat (12) @(posedge clk_i);
    sending = 1'b0;
  endtask

  task automatic set_geometry(int w, int h);
    write_reg(CFG_IMAGE_WIDTH, 24'(w));
    write_reg(CFG_IMAGE_HEIGHT, 24'(h));
  endtask

  task automatic set_taps(logic [23:0] t, logic [23:0] m, logic [23:0] b);
    write_reg(CFG_TAPS_TOP_ROW, t);
    write_reg(CFG_TAPS_MIDDLE_ROW, m);
    write_reg(CFG_TAPS_BOTTOM_ROW, b);
  endtask

  // Queue whole frames of random pixels; smooth-ish content when asked
  task automatic queue_frames(int w, int h, int nf, bit gentle);
    logic [15:0] base;
    for (int f = 0; f < nf; f++) begin
      base = 16'($urandom);
      for (int i = 0; i < w * h; i++) begin
        if (gentle) pixel_q.push_back(base ^ 16'($urandom_range(0, 3) << 1));
        else pixel_q.push_back(16'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_FLAT_THRESHOLD;
    cfg_wdata_i = '0;
    sending     = 1'b0;
    quiet       = 1'b0;
    errors      = 0;
    n_checked   = 0;
    n_smooth    = 0;
    n_frames    = 0;
    m_flat      = FLAT_RST;
    m_width     = WIDTH_RST;
    m_height    = HEIGHT_RST;
    m_taps[0]   = TAPS_T_RST;
    m_taps[1]   = TAPS_M_RST;
    m_taps[2]   = TAPS_B_RST;
    m_x         = 0;
    m_y         = 0;
    foreach (m_cols[i]) m_cols[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single pixel frame, single row, single column, extremes
    write_reg(CFG_FLAT_THRESHOLD, 24'd0);
    set_geometry(1, 1);
    pixel_q.push_back(16'h0000);
    pixel_q.push_back(16'hFFFF);
    drain();
    // Zero width and height behave as one
    set_geometry(0, 0);
    pixel_q.push_back(16'h1234);
    drain();
    set_geometry(4, 1);
    foreach (pixel_q[i]) ;
    pixel_q.push_back(16'hFFFF); pixel_q.push_back(16'h0000);
    pixel_q.push_back(16'hF800); pixel_q.push_back(16'h07E0);
    drain();
    set_geometry(1, 3);
    pixel_q.push_back(16'h001F); pixel_q.push_back(16'hFFFF); pixel_q.push_back(16'h0000);
    drain();
    // Strong sharpen with saturation both ways, max and min taps
    set_taps(24'h80FF7F, 24'h7F08FF, 24'h80FF7F);
    set_geometry(3, 3);
    pixel_q.push_back(16'hFFFF); pixel_q.push_back(16'h0000); pixel_q.push_back(16'hFFFF);
    pixel_q.push_back(16'h0000); pixel_q.push_back(16'hFFFF); pixel_q.push_back(16'h0000);
    pixel_q.push_back(16'h8410); pixel_q.push_back(16'h7BEF); pixel_q.push_back(16'hAAAA);
    drain();
    // Fully flat via maximum threshold
    write_reg(CFG_FLAT_THRESHOLD, 24'd255);
    set_geometry(2, 2);
    pixel_q.push_back(16'hFFFF); pixel_q.push_back(16'h0000);
    pixel_q.push_back(16'h5555); pixel_q.push_back(16'hFFFF);
    drain();

    // Random: small frames, mixed thresholds and kernels
    for (int ph = 0; ph < 10; ph++) begin
      int w, h;
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 5);
      write_reg(CFG_FLAT_THRESHOLD, 24'($urandom_range(0, 255)));
      if (ph % 3 == 0) set_taps(24'h00FF00, 24'hFF09FF, 24'h00FF00);
      else set_taps(24'($urandom), 24'($urandom), 24'($urandom));
      set_geometry(w, h);
      if (ph == 9) quiet = 1'b1;
      queue_frames(w, h, (ph < 9) ? 2 : 1, ph[0]);
      drain();
    end
    // One long row
    write_reg(CFG_FLAT_THRESHOLD, 24'd8);
    set_geometry(128, 1);
    queue_frames(128, 1, 1, 1'b1);
    drain();

    $display("Checked %0d results over %0d frames, %0d of them box averaged.",
             n_checked, n_frames, n_smooth);
    $display("Covered single pixel, row and column frames, zero geometry, a long row",
             " and saturation.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ass_pkg.sv
sv/ass_in_if.sv
sv/ass_out_if.sv
sv/ass_line_mem.sv
sv/ass_filter.sv
sv/adaptive_smooth_sharpen_3x3_rgb565.sv
tb/sv/tb_adaptive_smooth_sharpen_3x3_rgb565.sv
